// ----- rtl/core/mlh_pkg.sv -----
`default_nettype none
package mlh_pkg;

   localparam int MAX_LINES_DEF = 64;

   // request and result items
   typedef struct packed {
      logic               func;
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
      logic signed [31:0] query_x;
   } req_type;

   typedef struct packed {
      logic signed [63:0] best_value;
      logic               hull_empty;
      logic               table_full;
      logic               line_kept;
   } rsp_type;

   // one stored line
   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
   } line_type;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // which line sits in the middle of a redundancy test
   typedef enum logic [1:0] {
      MODE_NEW,
      MODE_RGT,
      MODE_LFT
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_S_RD, ST_S_CHK, ST_T1, ST_T2, ST_T3,
      ST_R_RD, ST_R_LD, ST_L_RD, ST_L_LD, ST_C_INIT, ST_C_RD, ST_C_WR, ST_C_NEW,
      ST_Q_LOOP, ST_Q_M1, ST_Q_M2, ST_Q_M3, ST_Q_M4, ST_Q_M5,
      ST_Q_F1, ST_Q_F2, ST_Q_F3, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_IDLE, OP_CHECK, OP_SCAN_RD, OP_SCAN_CHK, OP_TEST_A, OP_TEST_B, OP_TEST_DEC,
      OP_RGT_RD, OP_RGT_LD, OP_LFT_RD, OP_LFT_LD, OP_COPY_INIT, OP_COPY_RD,
      OP_COPY_WR, OP_COPY_NEW, OP_Q_LOOP, OP_Q_LD_A, OP_Q_MUL_A, OP_Q_MUL_B,
      OP_Q_SUM, OP_Q_CMP, OP_Q_LD_F, OP_Q_MUL_F, OP_Q_BEST, OP_DONE
   } op_type;

   typedef struct packed {
      op_type   op;
      mode_type mode;
      logic     accept;
   } cmd_type;

   typedef struct packed {
      logic func_qry;
      logic is_full;
      logic is_empty;
      logic scan_end;
      logic slope_gt;
      logic redundant;
      logic rgt_end;
      logic rgt_last;
      logic lk_zero;
      logic lk_one;
      logic copy_end;
      logic lo_lt_hi;
      logic mid_nx;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/mlh_ram.sv -----
`default_nettype none
module mlh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/mlh_ctrl.sv -----
`default_nettype none
module mlh_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire mlh_pkg::sts_type sts,
   output mlh_pkg::cmd_type      cmd,
   output logic                  busy,
   output logic                  rsp_strobe
);
   import mlh_pkg::*;

   state_type state_ff, state_in;
   mode_type  phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= MODE_NEW;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_CHECK;
         ST_CHECK: begin
            if (sts.func_qry) begin
               state_in = sts.is_empty ? ST_DONE : ST_Q_LOOP;
            end else begin
               state_in = sts.is_full ? ST_DONE : ST_S_RD;
               phase_in = MODE_NEW;
            end
         end
         ST_S_RD:  state_in = sts.scan_end ? ST_T1 : ST_S_CHK;
         ST_S_CHK: state_in = sts.slope_gt ? ST_T1 : ST_S_RD;
         ST_T1:    state_in = ST_T2;
         ST_T2:    state_in = ST_T3;
         ST_T3: begin
            case (phase_ff)
               MODE_NEW: begin
                  if (sts.redundant) begin
                     state_in = ST_DONE;
                  end else if (!sts.rgt_end) begin
                     state_in = ST_R_RD;
                     phase_in = MODE_RGT;
                  end else if (sts.lk_zero) begin
                     state_in = ST_C_INIT;
                  end else begin
                     state_in = ST_L_RD;
                     phase_in = MODE_LFT;
                  end
               end
               MODE_RGT: begin
                  if (sts.redundant && !sts.rgt_last) begin
                     state_in = ST_R_RD;
                  end else if (sts.lk_zero) begin
                     state_in = ST_C_INIT;
                  end else begin
                     state_in = ST_L_RD;
                     phase_in = MODE_LFT;
                  end
               end
               MODE_LFT: begin
                  state_in = (sts.redundant && !sts.lk_one) ? ST_L_RD : ST_C_INIT;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_R_RD:   state_in = sts.rgt_last ? ST_T1 : ST_R_LD;
         ST_R_LD:   state_in = ST_T1;
         ST_L_RD:   state_in = sts.lk_one ? ST_T1 : ST_L_LD;
         ST_L_LD:   state_in = ST_T1;
         ST_C_INIT: state_in = ST_C_RD;
         ST_C_RD:   state_in = sts.copy_end ? ST_C_NEW : ST_C_WR;
         ST_C_WR:   state_in = ST_C_RD;
         ST_C_NEW:  state_in = ST_DONE;
         ST_Q_LOOP: begin
            if (!sts.lo_lt_hi) begin
               state_in = ST_Q_F1;
            end else if (sts.mid_nx) begin
               state_in = ST_Q_M1;
            end
         end
         ST_Q_M1: state_in = ST_Q_M2;
         ST_Q_M2: state_in = ST_Q_M3;
         ST_Q_M3: state_in = ST_Q_M4;
         ST_Q_M4: state_in = ST_Q_M5;
         ST_Q_M5: state_in = ST_Q_LOOP;
         ST_Q_F1: state_in = ST_Q_F2;
         ST_Q_F2: state_in = ST_Q_F3;
         ST_Q_F3: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd.mode   = phase_ff;
      cmd.accept = (state_ff == ST_IDLE) && start;
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_DONE);
      case (state_ff)
         ST_IDLE:   cmd.op = OP_IDLE;
         ST_CHECK:  cmd.op = OP_CHECK;
         ST_S_RD:   cmd.op = OP_SCAN_RD;
         ST_S_CHK:  cmd.op = OP_SCAN_CHK;
         ST_T1:     cmd.op = OP_TEST_A;
         ST_T2:     cmd.op = OP_TEST_B;
         ST_T3:     cmd.op = OP_TEST_DEC;
         ST_R_RD:   cmd.op = OP_RGT_RD;
         ST_R_LD:   cmd.op = OP_RGT_LD;
         ST_L_RD:   cmd.op = OP_LFT_RD;
         ST_L_LD:   cmd.op = OP_LFT_LD;
         ST_C_INIT: cmd.op = OP_COPY_INIT;
         ST_C_RD:   cmd.op = OP_COPY_RD;
         ST_C_WR:   cmd.op = OP_COPY_WR;
         ST_C_NEW:  cmd.op = OP_COPY_NEW;
         ST_Q_LOOP: cmd.op = OP_Q_LOOP;
         ST_Q_M1:   cmd.op = OP_Q_LD_A;
         ST_Q_M2:   cmd.op = OP_Q_MUL_A;
         ST_Q_M3:   cmd.op = OP_Q_MUL_B;
         ST_Q_M4:   cmd.op = OP_Q_SUM;
         ST_Q_M5:   cmd.op = OP_Q_CMP;
         ST_Q_F1:   cmd.op = OP_Q_LD_F;
         ST_Q_F2:   cmd.op = OP_Q_MUL_F;
         ST_Q_F3:   cmd.op = OP_Q_BEST;
         ST_DONE:   cmd.op = OP_DONE;
         default:   cmd.op = OP_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/core/mlh_dpath.sv -----
`default_nettype none
module mlh_dpath #(
   parameter int MAX_LINES = mlh_pkg::MAX_LINES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mlh_pkg::req_type req_payload,
   input  wire mlh_pkg::cmd_type cmd,
   output mlh_pkg::sts_type      sts,
   output mlh_pkg::rsp_type      rsp_payload
);
   import mlh_pkg::*;

   localparam int CW = $clog2(MAX_LINES + 1);
   localparam int AW = $clog2(MAX_LINES);
   localparam logic [CW-1:0] ONE = CW'(1);

   logic              func_ff, func_in;
   line_type          new_ff, new_in, prv_ff, prv_in, nxt_ff, nxt_in, aux_ff, aux_in;
   logic signed [31:0] qx_ff, qx_in;
   logic [CW-1:0]     count_ff, count_in, idx_ff, idx_in, rgt_ff, rgt_in, lk_ff, lk_in;
   logic [CW-1:0]     cidx_ff, cidx_in, lo_ff, lo_in, hi_ff, hi_in, midr_ff, midr_in;
   logic              desc_ff, desc_in;
   logic signed [65:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [63:0] v1_ff, v1_in, v2_ff, v2_in;
   rsp_type           rsp_ff, rsp_in;

   line_type          rdata, lx, ly, lz;
   logic [$bits(line_type)-1:0] ram_rdata;
   logic              we;
   logic [CW-1:0]     raddr_w, waddr_w, mid;
   logic [CW:0]       lo_hi_sum;
   line_type          wdata;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic              hp, hn, eq_l, eq_r, lp, rp, red;

   mlh_ram #(.WIDTH($bits(line_type)), .DEPTH(MAX_LINES)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr_w[AW-1:0]),
      .wdata (wdata),
      .raddr (raddr_w[AW-1:0]),
      .rdata (ram_rdata)
   );
   assign rdata = line_type'(ram_rdata);

   // operand lines of the redundancy test
   always_comb begin
      case (cmd.mode)
         MODE_RGT: begin
            lx = new_ff; ly = nxt_ff; lz = aux_ff;
            hp = 1'b1;   hn = (rgt_ff + ONE) != count_ff;
         end
         MODE_LFT: begin
            lx = aux_ff; ly = prv_ff; lz = new_ff;
            hp = (lk_ff != ONE); hn = 1'b1;
         end
         default: begin
            lx = prv_ff; ly = new_ff; lz = nxt_ff;
            hp = (lk_ff != '0); hn = (rgt_ff != count_ff);
         end
      endcase
   end

   // redundancy decision: equal slopes first, else crossing products
   always_comb begin
      eq_l = (ly.slope == lx.slope);
      eq_r = (lz.slope == ly.slope);
      lp   = eq_l && (lx.intercept > ly.intercept);
      rp   = eq_r && (ly.intercept > lz.intercept);
      if (!hp) begin
         red = hn && eq_r && (ly.intercept <= lz.intercept);
      end else if (!hn) begin
         red = eq_l && (ly.intercept <= lx.intercept);
      end else if (lp) begin
         red = 1'b1;
      end else if (eq_l) begin
         red = eq_r && !rp;
      end else if (rp) begin
         red = 1'b0;
      end else if (eq_r) begin
         red = 1'b1;
      end else begin
         red = (p1_ff >= p2_ff);
      end
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_TEST_A: begin
            mul_a = 33'({lx.intercept[31], lx.intercept}) - 33'({ly.intercept[31], ly.intercept});
            mul_b = 33'({lz.slope[31], lz.slope}) - 33'({ly.slope[31], ly.slope});
         end
         OP_TEST_B: begin
            mul_a = 33'({ly.intercept[31], ly.intercept}) - 33'({lz.intercept[31], lz.intercept});
            mul_b = 33'({ly.slope[31], ly.slope}) - 33'({lx.slope[31], lx.slope});
         end
         OP_Q_MUL_A, OP_Q_MUL_F: begin
            mul_a = {aux_ff.slope[31], aux_ff.slope};
            mul_b = {qx_ff[31], qx_ff};
         end
         OP_Q_MUL_B: begin
            mul_a = {nxt_ff.slope[31], nxt_ff.slope};
            mul_b = {qx_ff[31], qx_ff};
         end
         default: ;
      endcase
      prod = mul_a * mul_b;
   end

   // binary search midpoint
   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = lo_hi_sum[CW:1];

   // status toward the controller
   always_comb begin
      sts.func_qry  = (func_ff == FUNC_QUERY);
      sts.is_full   = (count_ff == CW'(MAX_LINES));
      sts.is_empty  = (count_ff == '0);
      sts.scan_end  = (idx_ff == count_ff);
      sts.slope_gt  = (rdata.slope > new_ff.slope);
      sts.redundant = red;
      sts.rgt_end   = (rgt_ff == count_ff);
      sts.rgt_last  = ((rgt_ff + ONE) == count_ff);
      sts.lk_zero   = (lk_ff == '0);
      sts.lk_one    = (lk_ff == ONE);
      sts.copy_end  = desc_ff ? (cidx_ff == rgt_ff) : (cidx_ff == count_ff);
      sts.lo_lt_hi  = (lo_ff < hi_ff);
      sts.mid_nx    = ({1'b0, mid} + {1'b0, ONE}) < {1'b0, count_ff};
   end

   // datapath register updates per command
   always_comb begin
      func_in  = func_ff;  new_in  = new_ff;  qx_in   = qx_ff;
      prv_in   = prv_ff;   nxt_in  = nxt_ff;  aux_in  = aux_ff;
      count_in = count_ff; idx_in  = idx_ff;  rgt_in  = rgt_ff;  lk_in = lk_ff;
      cidx_in  = cidx_ff;  lo_in   = lo_ff;   hi_in   = hi_ff;   midr_in = midr_ff;
      desc_in  = desc_ff;  p1_in   = p1_ff;   p2_in   = p2_ff;
      v1_in    = v1_ff;    v2_in   = v2_ff;   rsp_in  = rsp_ff;
      raddr_w  = idx_ff;   waddr_w = lk_ff;   wdata   = new_ff;  we = 1'b0;
      case (cmd.op)
         OP_IDLE: begin
            if (cmd.accept) begin
               func_in          = req_payload.func;
               new_in.slope     = req_payload.slope;
               new_in.intercept = req_payload.intercept;
               qx_in            = req_payload.query_x;
               rsp_in           = '0;
            end
         end
         OP_CHECK: begin
            idx_in = '0;
            lo_in  = '0;
            hi_in  = count_ff;
            if (func_ff == FUNC_QUERY) begin
               rsp_in.hull_empty = (count_ff == '0);
            end else begin
               rsp_in.table_full = (count_ff == CW'(MAX_LINES));
            end
         end
         OP_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               rgt_in = count_ff;
               lk_in  = count_ff;
            end
         end
         OP_SCAN_CHK: begin
            if (rdata.slope > new_ff.slope) begin
               nxt_in = rdata;
               rgt_in = idx_ff;
               lk_in  = idx_ff;
            end else begin
               prv_in = rdata;
               idx_in = idx_ff + ONE;
            end
         end
         OP_TEST_A: p1_in = prod;
         OP_TEST_B: p2_in = prod;
         OP_TEST_DEC: begin
            if (red && cmd.mode == MODE_RGT) begin
               rgt_in = rgt_ff + ONE;
               nxt_in = aux_ff;
            end else if (red && cmd.mode == MODE_LFT) begin
               lk_in  = lk_ff - ONE;
               prv_in = aux_ff;
            end
         end
         OP_RGT_RD: raddr_w = rgt_ff + ONE;
         OP_LFT_RD: raddr_w = lk_ff - CW'(2);
         OP_RGT_LD, OP_LFT_LD, OP_Q_LD_F: aux_in = rdata;
         OP_COPY_INIT: begin
            desc_in = (lk_ff == rgt_ff);
            cidx_in = (lk_ff == rgt_ff) ? count_ff : rgt_ff;
         end
         OP_COPY_RD: raddr_w = desc_ff ? (cidx_ff - ONE) : cidx_ff;
         OP_COPY_WR: begin
            we      = 1'b1;
            wdata   = rdata;
            waddr_w = desc_ff ? cidx_ff : (cidx_ff - rgt_ff + lk_ff + ONE);
            cidx_in = desc_ff ? (cidx_ff - ONE) : (cidx_ff + ONE);
         end
         OP_COPY_NEW: begin
            we               = 1'b1;
            count_in         = lk_ff + ONE + count_ff - rgt_ff;
            rsp_in.line_kept = 1'b1;
         end
         OP_Q_LOOP: begin
            if (lo_ff < hi_ff) begin
               raddr_w = mid;
               if (sts.mid_nx) begin
                  midr_in = mid;
               end else begin
                  hi_in = mid;
               end
            end else begin
               raddr_w = lo_ff;
            end
         end
         OP_Q_LD_A: begin
            aux_in  = rdata;
            raddr_w = midr_ff + ONE;
         end
         OP_Q_MUL_A: begin
            p1_in  = prod;
            nxt_in = rdata;
         end
         OP_Q_MUL_B: p2_in = prod;
         OP_Q_SUM: begin
            v1_in = p1_ff[63:0] + {{32{aux_ff.intercept[31]}}, aux_ff.intercept};
            v2_in = p2_ff[63:0] + {{32{nxt_ff.intercept[31]}}, nxt_ff.intercept};
         end
         OP_Q_CMP: begin
            if (v1_ff < v2_ff) begin
               lo_in = midr_ff + ONE;
            end else begin
               hi_in = midr_ff;
            end
         end
         OP_Q_MUL_F: p1_in = prod;
         OP_Q_BEST: begin
            rsp_in.best_value = p1_ff[63:0] + {{32{aux_ff.intercept[31]}}, aux_ff.intercept};
         end
         default: ;
      endcase
   end

   // line count is the only register here with a reset
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;  new_ff <= new_in;  qx_ff   <= qx_in;
      prv_ff  <= prv_in;   nxt_ff <= nxt_in;  aux_ff  <= aux_in;
      idx_ff  <= idx_in;   rgt_ff <= rgt_in;  lk_ff   <= lk_in;
      cidx_ff <= cidx_in;  lo_ff  <= lo_in;   hi_ff   <= hi_in;   midr_ff <= midr_in;
      desc_ff <= desc_in;  p1_ff  <= p1_in;   p2_ff   <= p2_in;
      v1_ff   <= v1_in;    v2_ff  <= v2_in;   rsp_ff  <= rsp_in;
   end

   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

// ----- rtl/core/max_line_hull_container.sv -----
// channel   ports                          direction  accepted when
// request   start, busy, req_payload       in         start high and busy low
// result    rsp_strobe, rsp_payload        out        every cycle rsp_strobe is high
//
// one request at a time; busy stays high until its result has been shown.
// insert: scans the stored lines for its slot, tests the new line and then its neighbours,
//   then moves the stored lines and writes the new line.
// query: a binary search over the stored lines; full or empty: answered without a search.
// reset clears the line count and the controller state only; no clearing pass over the table.
// the result is shown for one cycle and cannot be stalled.
`default_nettype none
module max_line_hull_container #(
   parameter int MAX_LINES = mlh_pkg::MAX_LINES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mlh_pkg::req_type req_payload,
   output logic                  rsp_strobe,
   output mlh_pkg::rsp_type      rsp_payload
);
   import mlh_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mlh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mlh_dpath #(.MAX_LINES(MAX_LINES)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );
endmodule
`default_nettype wire

// ----- rtl/core/mlh_checker.sv -----
`default_nettype none
module mlh_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_strobe,
   input wire mlh_pkg::rsp_type rsp_payload
);
   // a result only appears while a request is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result outside a request");

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted request not taken");

   // the block is free right after its result
   a_free_after: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("still busy after result");

   // an empty hull answers zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.hull_empty) |-> (rsp_payload.best_value == 64'sd0))
      else $error("empty hull with nonzero value");

   // a dropped insert never keeps its line
   a_full_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_payload.table_full && rsp_payload.line_kept))
      else $error("full and kept together");
endmodule

bind max_line_hull_container mlh_checker u_chk (.*);
`default_nettype wire
